>>> rtl/ubfr_pkg.sv
// Package for the serial file-upload receiver.
// Holds beat structs, phase and code constants and the result builder.
// No dependencies.
`default_nettype none

package ubfr_pkg;

    // Payload bytes per frame after the count byte
    localparam logic [7:0] FRAME_PAYLOAD = 8'd255;
    localparam logic [24:0] OFFSET_MAX = 25'h1FF_FFFF;
    localparam logic [7:0] HEADER_BYTES = 8'd4;

    // Reset values of the configuration registers
    localparam logic [31:0] RST_LOAD_BASE = 32'd0;
    localparam logic [15:0] RST_TIMEOUT = 16'd10000;
    localparam logic [23:0] RST_MAX_SIZE = 24'd917504;

    // Configuration register indexes
    localparam logic [1:0] CFG_LOAD_BASE = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_MAX_SIZE = 2'd2;

    // Request codes
    localparam logic [1:0] REQ_BYTE = 2'd0;
    localparam logic [1:0] REQ_TICK = 2'd1;
    localparam logic [1:0] REQ_START = 2'd2;

    // Result kinds
    localparam logic [2:0] KIND_WRITE = 3'd0;
    localparam logic [2:0] KIND_TX = 3'd1;
    localparam logic [2:0] KIND_DONE = 3'd2;
    localparam logic [2:0] KIND_TIMEOUT = 3'd3;
    localparam logic [2:0] KIND_SIZE_ERR = 3'd4;

    // Acknowledge characters
    localparam logic [7:0] CHAR_O = 8'h4F;
    localparam logic [7:0] CHAR_K = 8'h4B;

    // Most results one input beat can cause
    localparam int MAX_RES = 6;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HEADER = 2'd1,
        PH_FRAME  = 2'd2
    } t_phase;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  res_kind;
        logic [31:0] mem_addr;
        logic [7:0]  data_byte;
        logic        last;
    } t_out_item;

    // Build one result with the last flag clear
    function automatic t_out_item make_res(input logic [2:0] kind,
                                           input logic [31:0] addr,
                                           input logic [7:0] data);
        t_out_item r;
        r.res_kind = kind;
        r.mem_addr = addr;
        r.data_byte = data;
        r.last = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/uart_block_file_receiver.sv
// Serial file-upload receiver: protocol state, result list and output drain.
// Depends on ubfr_pkg for beat structs, phase enum and codes.
// A beat's results are registered and offered from the cycle after it is taken.
// Throughput: one input beat per cycle while each causes at most one result and
// the output is ready; a beat causing more results holds the input until all but
// its final result have drained (the list drains one beat per cycle while ready).
// Reset (synchronous, active low) clears protocol state, empties the result
// list and loads the configuration registers with their defaults.
`default_nettype none

module uart_block_file_receiver (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [1:0]          i_cfg_idx,
    input  wire logic [31:0]         i_cfg_data,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire ubfr_pkg::t_in_item  i_in,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output ubfr_pkg::t_out_item      o_out
);

    // Configuration registers
    logic [31:0] r_load_base;
    logic [15:0] r_timeout;
    logic [23:0] r_max_size;

    // Protocol state
    ubfr_pkg::t_phase r_phase, n_phase;
    logic [7:0]  r_pos, n_pos;
    logic [7:0]  r_fcount, n_fcount;
    logic [24:0] r_offset, n_offset;
    logic [15:0] r_sum, n_sum;
    logic [15:0] r_tick, n_tick;

    // Result list
    ubfr_pkg::t_out_item r_list [ubfr_pkg::MAX_RES];
    ubfr_pkg::t_out_item n_list [ubfr_pkg::MAX_RES];
    logic [2:0] n_cnt;
    logic [2:0] r_rd;
    logic [2:0] r_left;

    logic in_take, out_take, active;
    logic [15:0] tick_inc;
    logic [7:0]  fc_eff, used;
    logic        do_write;
    logic [31:0] wr_addr;

    assign out_take = o_out_valid && i_out_ready;
    assign o_out_valid = (r_left != 3'd0);
    assign o_out = r_list[r_rd];
    // Take a new beat once the list is empty or its final entry leaves now
    assign o_in_ready = (r_left == 3'd0) || ((r_left == 3'd1) && i_out_ready);
    assign in_take = i_in_valid && o_in_ready;

    assign active = (r_phase == ubfr_pkg::PH_HEADER) || (r_phase == ubfr_pkg::PH_FRAME);
    assign tick_inc = r_tick + 16'd1;
    assign fc_eff = (r_pos == 8'd0) ? i_in.rx_byte : r_fcount;
    assign used = (fc_eff > ubfr_pkg::FRAME_PAYLOAD) ? ubfr_pkg::FRAME_PAYLOAD : fc_eff;
    assign do_write = (r_pos != 8'd0) && (r_pos <= used);
    assign wr_addr = r_load_base + {7'd0, r_offset};

    // Next protocol state and the results of the offered beat
    always_comb begin
        n_phase = r_phase;
        n_pos = r_pos;
        n_fcount = r_fcount;
        n_offset = r_offset;
        n_sum = r_sum;
        n_tick = r_tick;
        n_cnt = 3'd0;
        for (int i = 0; i < ubfr_pkg::MAX_RES; i++) begin
            n_list[i] = ubfr_pkg::make_res(ubfr_pkg::KIND_DONE, 32'd0, 8'd0);
        end

        case (i_in.req_type)
            ubfr_pkg::REQ_START: begin
                n_phase = ubfr_pkg::PH_HEADER;
                n_pos = 8'd0;
                n_fcount = 8'd0;
                n_offset = 25'd0;
                n_sum = 16'd0;
                n_tick = 16'd0;
            end
            ubfr_pkg::REQ_TICK: begin
                if (active) begin
                    n_tick = tick_inc;
                    if ((tick_inc == 16'd0) || (tick_inc >= r_timeout)) begin
                        n_phase = ubfr_pkg::PH_IDLE;
                        n_pos = 8'd0;
                        n_tick = 16'd0;
                        n_list[n_cnt] = ubfr_pkg::make_res(ubfr_pkg::KIND_TIMEOUT,
                                                           32'd0, 8'd0);
                        n_cnt = n_cnt + 3'd1;
                    end
                end
            end
            ubfr_pkg::REQ_BYTE: begin
                if (r_phase == ubfr_pkg::PH_HEADER) begin
                    // Count header bytes, then acknowledge
                    n_pos = r_pos + 8'd1;
                    if (n_pos >= ubfr_pkg::HEADER_BYTES) begin
                        n_list[0] = ubfr_pkg::make_res(ubfr_pkg::KIND_TX, 32'd0,
                                                       ubfr_pkg::CHAR_O);
                        n_list[1] = ubfr_pkg::make_res(ubfr_pkg::KIND_TX, 32'd0,
                                                       ubfr_pkg::CHAR_K);
                        n_cnt = 3'd2;
                        n_phase = ubfr_pkg::PH_FRAME;
                        n_pos = 8'd0;
                        n_tick = 16'd0;
                    end
                end else if (r_phase == ubfr_pkg::PH_FRAME) begin
                    n_fcount = fc_eff;
                    // Write a payload byte that the count covers
                    if (do_write) begin
                        n_list[n_cnt] = ubfr_pkg::make_res(ubfr_pkg::KIND_WRITE,
                                                           wr_addr, i_in.rx_byte);
                        n_cnt = n_cnt + 3'd1;
                        n_sum = r_sum + {8'd0, i_in.rx_byte};
                        if (r_offset < ubfr_pkg::OFFSET_MAX) begin
                            n_offset = r_offset + 25'd1;
                        end
                    end
                    // Close the frame on its final byte
                    if (r_pos >= ubfr_pkg::FRAME_PAYLOAD) begin
                        n_list[n_cnt] = ubfr_pkg::make_res(ubfr_pkg::KIND_TX, 32'd0,
                                                           ubfr_pkg::CHAR_O);
                        n_cnt = n_cnt + 3'd1;
                        n_list[n_cnt] = ubfr_pkg::make_res(ubfr_pkg::KIND_TX, 32'd0,
                                                           ubfr_pkg::CHAR_K);
                        n_cnt = n_cnt + 3'd1;
                        n_pos = 8'd0;
                        n_tick = 16'd0;
                        if (fc_eff != ubfr_pkg::FRAME_PAYLOAD) begin
                            n_phase = ubfr_pkg::PH_IDLE;
                            if (n_offset > {1'b0, r_max_size}) begin
                                n_list[n_cnt] = ubfr_pkg::make_res(
                                    ubfr_pkg::KIND_SIZE_ERR, 32'd0, 8'd0);
                                n_cnt = n_cnt + 3'd1;
                            end else begin
                                n_list[n_cnt] = ubfr_pkg::make_res(
                                    ubfr_pkg::KIND_TX, 32'd0, n_sum[7:0]);
                                n_cnt = n_cnt + 3'd1;
                                n_list[n_cnt] = ubfr_pkg::make_res(
                                    ubfr_pkg::KIND_TX, 32'd0, n_sum[15:8]);
                                n_cnt = n_cnt + 3'd1;
                                n_list[n_cnt] = ubfr_pkg::make_res(
                                    ubfr_pkg::KIND_DONE, 32'd0, 8'd0);
                                n_cnt = n_cnt + 3'd1;
                            end
                        end
                    end else begin
                        n_pos = r_pos + 8'd1;
                    end
                end
            end
            default: begin
                n_cnt = 3'd0;
            end
        endcase

        // Flag the final entry of the beat
        for (int i = 0; i < ubfr_pkg::MAX_RES; i++) begin
            n_list[i].last = (3'(i) == (n_cnt - 3'd1));
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_base <= ubfr_pkg::RST_LOAD_BASE;
            r_timeout <= ubfr_pkg::RST_TIMEOUT;
            r_max_size <= ubfr_pkg::RST_MAX_SIZE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ubfr_pkg::CFG_LOAD_BASE: r_load_base <= i_cfg_data;
                ubfr_pkg::CFG_TIMEOUT: r_timeout <= i_cfg_data[15:0];
                ubfr_pkg::CFG_MAX_SIZE: r_max_size <= i_cfg_data[23:0];
                default: r_load_base <= r_load_base;
            endcase
        end
    end

    // Advance protocol state on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ubfr_pkg::PH_IDLE;
            r_pos <= 8'd0;
            r_fcount <= 8'd0;
            r_offset <= 25'd0;
            r_sum <= 16'd0;
            r_tick <= 16'd0;
        end else if (in_take) begin
            r_phase <= n_phase;
            r_pos <= n_pos;
            r_fcount <= n_fcount;
            r_offset <= n_offset;
            r_sum <= n_sum;
            r_tick <= n_tick;
        end
    end

    // Drain the result list, reload it on an accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= 3'd0;
            r_left <= 3'd0;
        end else if (in_take) begin
            r_rd <= 3'd0;
            r_left <= n_cnt;
        end else if (out_take) begin
            r_rd <= r_rd + 3'd1;
            r_left <= r_left - 3'd1;
        end
    end

    // Hold result payloads of the accepted beat
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            for (int i = 0; i < ubfr_pkg::MAX_RES; i++) begin
                r_list[i] <= n_list[i];
            end
        end
    end

endmodule

`default_nettype wire

>>> tb/ubfr_checker.sv
// Checker for the serial file-upload receiver: follows register writes and accepted
// input beats, predicts every result beat and compares the output channel against it.
// Depends on ubfr_pkg for beat structs, the phase enum and the code constants.
`timescale 1ns / 1ps

module ubfr_checker (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [1:0]          i_cfg_idx,
    input  wire logic [31:0]         i_cfg_data,
    input  wire logic                i_in_valid,
    input  wire logic                i_in_ready,
    input  wire ubfr_pkg::t_in_item  i_in,
    input  wire logic                i_out_valid,
    input  wire logic                i_out_ready,
    input  wire ubfr_pkg::t_out_item i_out,
    output int                       o_err_count,
    output int                       o_pending
);
    import ubfr_pkg::*;

    // Shadow registers
    logic [31:0] base_q;
    logic [15:0] tmo_q;
    logic [23:0] max_q;

    // Shadow protocol state
    t_phase      ph;
    logic [7:0]  pos;
    logic [7:0]  frame_len;
    logic [24:0] offset;
    logic [15:0] csum;
    logic [15:0] ticks;

    t_out_item   due_beats[$];   // result beats the block still owes
    t_out_item   step_beats[$];  // result beats caused by one input beat
    int          err_total = 0;

    task automatic add_beat(input logic [2:0] kind, input logic [31:0] addr,
                            input logic [7:0] data);
        t_out_item r;
        r.res_kind = kind;
        r.mem_addr = addr;
        r.data_byte = data;
        r.last = 1'b0;
        step_beats.push_back(r);
    endtask

    task automatic add_ok();
        add_beat(KIND_TX, 32'd0, CHAR_O);
        add_beat(KIND_TX, 32'd0, CHAR_K);
    endtask

    // Advance the header or frame on one received byte
    task automatic take_rx_byte(input logic [7:0] b);
        logic [7:0] used;
        used = (frame_len > FRAME_PAYLOAD) ? FRAME_PAYLOAD : frame_len;
        if (ph == PH_HEADER) begin
            pos = pos + 8'd1;
            if (pos >= HEADER_BYTES) begin
                add_ok();
                ph = PH_FRAME;
                pos = 8'd0;
                ticks = 16'd0;
            end
        end else if (ph == PH_FRAME) begin
            if (pos == 8'd0) begin
                frame_len = b;
            end else if (pos <= used) begin
                add_beat(KIND_WRITE, base_q + {7'd0, offset}, b);
                csum = csum + {8'd0, b};
                if (offset < OFFSET_MAX)
                    offset = offset + 25'd1;
            end
            if (pos >= FRAME_PAYLOAD) begin
                add_ok();
                pos = 8'd0;
                ticks = 16'd0;
                // A short frame closes the transfer
                if (frame_len != FRAME_PAYLOAD) begin
                    ph = PH_IDLE;
                    if ({7'd0, offset} > {8'd0, max_q}) begin
                        add_beat(KIND_SIZE_ERR, 32'd0, 8'd0);
                    end else begin
                        add_beat(KIND_TX, 32'd0, csum[7:0]);
                        add_beat(KIND_TX, 32'd0, csum[15:8]);
                        add_beat(KIND_DONE, 32'd0, 8'd0);
                    end
                end
            end else begin
                pos = pos + 8'd1;
            end
        end
    endtask

    // Predict the result beats of one accepted input beat
    task automatic upload_step(input t_in_item it);
        logic active;
        step_beats.delete();
        active = (ph == PH_HEADER) || (ph == PH_FRAME);
        case (it.req_type)
            REQ_START: begin
                ph = PH_HEADER;
                pos = 8'd0;
                frame_len = 8'd0;
                offset = 25'd0;
                csum = 16'd0;
                ticks = 16'd0;
            end
            REQ_TICK: begin
                if (active) begin
                    ticks = ticks + 16'd1;
                    if (ticks == 16'd0 || ticks >= tmo_q) begin
                        ph = PH_IDLE;
                        pos = 8'd0;
                        ticks = 16'd0;
                        add_beat(KIND_TIMEOUT, 32'd0, 8'd0);
                    end
                end
            end
            REQ_BYTE: begin
                if (active)
                    take_rx_byte(it.rx_byte);
            end
            default: ;
        endcase
        if (step_beats.size() > 0)
            step_beats[step_beats.size() - 1].last = 1'b1;
        foreach (step_beats[k])
            due_beats.push_back(step_beats[k]);
    endtask

    task automatic report_mismatch(input string what, input t_out_item got,
                                   input t_out_item want);
        err_total++;
        $display({"%0t mismatch (%s): got kind %0d addr %h data %h last %b, ",
                  "want kind %0d addr %h data %h last %b"},
                 $realtime, what, got.res_kind, got.mem_addr, got.data_byte, got.last,
                 want.res_kind, want.mem_addr, want.data_byte, want.last);
    endtask

    always @(posedge i_clk) begin : watch_edge
        t_out_item want;
        if (!i_rst_n) begin
            base_q = RST_LOAD_BASE;
            tmo_q = RST_TIMEOUT;
            max_q = RST_MAX_SIZE;
            ph = PH_IDLE;
            pos = 8'd0;
            frame_len = 8'd0;
            offset = 25'd0;
            csum = 16'd0;
            ticks = 16'd0;
            due_beats.delete();
        end else begin
            // Check the output beat before predicting from this edge's input
            if (i_out_valid && i_out_ready) begin
                if (due_beats.size() == 0) begin
                    report_mismatch("no beat due", i_out, '0);
                end else begin
                    want = due_beats.pop_front();
                    if (i_out.res_kind !== want.res_kind || i_out.mem_addr !== want.mem_addr
                            || i_out.data_byte !== want.data_byte || i_out.last !== want.last)
                        report_mismatch("field", i_out, want);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LOAD_BASE: base_q = i_cfg_data;
                    CFG_TIMEOUT:   tmo_q = i_cfg_data[15:0];
                    CFG_MAX_SIZE:  max_q = i_cfg_data[23:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                upload_step(i_in);
        end
        o_pending <= due_beats.size();
        o_err_count <= err_total;
    end

endmodule

>>> tb/tb_top.sv
// Testbench top for the serial file-upload receiver: clock, reset, register writes,
// upload stimulus with sender gaps and receiver stalls, watchdog and verdict.
// Depends on ubfr_pkg, uart_block_file_receiver and ubfr_checker.
`timescale 1ns / 1ps

module tb_top;
    import ubfr_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS = 10;
    localparam int NUM_PHASES = 6;
    localparam int SETTLE_CYCLES = 4;
    localparam logic [1:0] REQ_SPARE = 2'd3;

    typedef enum int {
        STALL_NONE,
        STALL_COIN,
        STALL_SPARSE,
        STALL_COMB
    } t_stall;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_idx = '0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    t_in_item    in_beat = '0;
    logic        in_ready;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_item   out_beat;
    int          err_count;
    int          pending_count;

    int          burst_left = 0;
    int          rand_items = 0;
    int          idle_cycles = 0;
    t_stall      ready_mode = STALL_NONE;
    int          mode_left = 0;
    int          ready_phase = 0;

    always #5 i_clk = ~i_clk;

    uart_block_file_receiver dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_beat)
    );

    ubfr_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in        (in_beat),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out       (out_beat),
        .o_err_count (err_count),
        .o_pending   (pending_count)
    );

    // Stall the result channel, switching to a new random pattern whenever its count runs out
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            ready_mode <= t_stall'($urandom_range(0, 3));
            mode_left <= $urandom_range(16, 96);
        end else begin
            mode_left <= mode_left - 1;
        end
        ready_phase <= ready_phase + 1;
        case (ready_mode)
            STALL_NONE:   out_ready <= 1'b1;
            STALL_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
            STALL_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
            default:      out_ready <= ((ready_phase % 4) == 3);
        endcase
    end

    // End the run when no beat moves on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one input beat and hold it until taken; open a gap between bursts
    task automatic send_beat(input logic [1:0] req, input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 24);
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_beat <= '{req_type: req, rx_byte: b};
        do @(posedge i_clk); while (!in_ready);
        rand_items++;
    endtask

    // Send a received byte, now and then preceded by a timer tick
    task automatic send_data_byte(input logic [7:0] b, input int tick_odds);
        if (tick_odds > 0 && $urandom_range(1, tick_odds) == 1)
            send_beat(REQ_TICK, 8'($urandom_range(0, 255)));
        send_beat(REQ_BYTE, b);
    endtask

    // Full upload: start, header, full frames, then one short frame
    task automatic send_transfer(input int full_frames, input logic [7:0] final_len,
                                 input int tick_odds);
        send_beat(REQ_START, 8'($urandom_range(0, 255)));
        repeat (HEADER_BYTES) send_data_byte(8'($urandom_range(0, 255)), tick_odds);
        for (int f = 0; f <= full_frames; f++) begin
            send_data_byte((f < full_frames) ? FRAME_PAYLOAD : final_len, tick_odds);
            repeat (FRAME_PAYLOAD) send_data_byte(8'($urandom_range(0, 255)), tick_odds);
        end
    endtask

    // Start followed by a jumble of bytes, ticks, restarts and spare codes
    task automatic send_broken();
        int pick;
        send_beat(REQ_START, 8'($urandom_range(0, 255)));
        repeat ($urandom_range(1, 24)) begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
                send_beat(REQ_BYTE, 8'($urandom_range(0, 255)));
            else if (pick == 7)
                send_beat(REQ_TICK, 8'($urandom_range(0, 255)));
            else if (pick == 8)
                send_beat(REQ_START, 8'($urandom_range(0, 255)));
            else
                send_beat(REQ_SPARE, 8'($urandom_range(0, 255)));
        end
    endtask

    // Beats offered while idle are dropped by the block and are not counted
    task automatic send_idle_noise();
        logic [1:0] codes [3] = '{REQ_BYTE, REQ_TICK, REQ_SPARE};
        int saved;
        saved = rand_items;
        repeat ($urandom_range(1, 4))
            send_beat(codes[$urandom_range(0, 2)], 8'($urandom_range(0, 255)));
        rand_items = saved;
    endtask

    // Drop valid and wait until every due result beat has drained
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Load all three registers for one phase and pick a tick density to suit
    task automatic choose_settings(input int p, output int tick_odds);
        logic [31:0] base;
        logic [15:0] tmo;
        logic [23:0] limit;
        case (p)
            0: begin
                base = 32'hFFFF_FF00;
                tmo = 16'hFFFF;
                limit = 24'($urandom_range(0, 255));
            end
            1: begin
                base = 32'd0;
                tmo = RST_TIMEOUT;
                limit = 24'd0;
            end
            2: begin
                base = $urandom;
                tmo = 16'($urandom_range(2, 40));
                limit = 24'($urandom_range(0, 800));
            end
            default: begin
                case ($urandom_range(0, 3))
                    0:       base = 32'd0;
                    1:       base = 32'hFFFF_FFFF - $urandom_range(0, 600);
                    2:       base = 32'hFFFF_FFFF;
                    default: base = $urandom;
                endcase
                case ($urandom_range(0, 4))
                    0:       tmo = 16'd0;
                    1:       tmo = 16'd1;
                    2:       tmo = 16'hFFFF;
                    3:       tmo = 16'($urandom_range(2, 64));
                    default: tmo = 16'($urandom_range(1, 65535));
                endcase
                case ($urandom_range(0, 3))
                    0:       limit = 24'd0;
                    1:       limit = 24'hFF_FFFF;
                    2:       limit = 24'($urandom_range(0, 800));
                    default: limit = 24'($urandom);
                endcase
            end
        endcase
        write_reg(CFG_LOAD_BASE, base);
        write_reg(CFG_TIMEOUT, {16'd0, tmo});
        write_reg(CFG_MAX_SIZE, {8'd0, limit});
        // Aim for roughly as many ticks per frame as the timeout allows
        if (tmo < 16'd300)
            tick_odds = 256 / (int'(tmo) + 2) + 1;
        else
            tick_odds = ($urandom_range(0, 2) == 0) ? 0 : 6;
    endtask

    initial begin : stimulus
        int tick_odds;
        logic [7:0] final_len;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero timeout, empty size budget, base just below the wrap
        write_reg(CFG_LOAD_BASE, 32'hFFFF_FFFE);
        write_reg(CFG_TIMEOUT, 32'd0);
        write_reg(CFG_MAX_SIZE, 32'd0);

        // Byte, tick and spare code while idle: all dropped
        send_beat(REQ_BYTE, 8'hFF);
        send_beat(REQ_TICK, 8'h00);
        send_beat(REQ_SPARE, 8'hA5);

        // Header answered with OK, then one tick aborts under a zero timeout
        send_beat(REQ_START, 8'h00);
        send_beat(REQ_BYTE, 8'h00);
        send_beat(REQ_BYTE, 8'hFF);
        send_beat(REQ_BYTE, 8'h5A);
        send_beat(REQ_BYTE, 8'hA5);
        send_beat(REQ_TICK, 8'hFF);

        // Restart mid-header, then a partial frame whose writes wrap the address
        send_beat(REQ_START, 8'hFF);
        send_beat(REQ_BYTE, 8'h12);
        send_beat(REQ_BYTE, 8'h34);
        send_beat(REQ_START, 8'h55);
        repeat (4) send_beat(REQ_BYTE, 8'h00);
        send_beat(REQ_BYTE, 8'd3);
        send_beat(REQ_BYTE, 8'hFF);
        send_beat(REQ_BYTE, 8'h00);
        send_beat(REQ_BYTE, 8'h7E);

        // Restart mid-frame keeps the writes made; abort in the header
        send_beat(REQ_START, 8'h0F);
        send_beat(REQ_TICK, 8'hF0);

        // Timeout of one tick
        wait_idle();
        write_reg(CFG_TIMEOUT, 32'd1);
        send_beat(REQ_START, 8'h3C);
        send_beat(REQ_BYTE, 8'hC3);
        send_beat(REQ_TICK, 8'h00);

        // Random phases: one complete upload first, then broken sequences
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            choose_settings(p, tick_odds);
            rand_items = 0;
            if (p == 0) begin
                case ($urandom_range(0, 3))
                    0:       final_len = 8'd0;
                    1:       final_len = FRAME_PAYLOAD - 8'd1;
                    default: final_len = 8'($urandom_range(1, 254));
                endcase
                send_transfer(0, final_len, tick_odds);
            end else begin
                while (rand_items < PHASE_ITEMS) begin
                    send_broken();
                    if ($urandom_range(0, 2) == 0)
                        send_idle_noise();
                end
            end
        end

        wait_idle();
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
